/* sv/fgcn_pkg.sv */
package fgcn_pkg;

  // Node numbers travel on the ports as seven-bit values, numbered from one.
  localparam int NODE_W        = 7;
  localparam int MAX_NODES_DEF = 64;

  typedef struct packed {
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
    logic              last_edge;
  } in_beat_t;

  typedef struct packed {
    logic [NODE_W-1:0] cycle_node;
    logic              last_node;
    logic              overflow;
  } out_beat_t;

  // Requests from the sequencer to the work queue.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_INC,
    ST_PTR,
    ST_SCAN,
    ST_POP,
    ST_NODE,
    ST_TGT,
    ST_DEC,
    ST_E_RD,
    ST_E_CHK,
    ST_E_WAIT
  } state_t;

endpackage

/* sv/fgcn_queue.sv */
module fgcn_queue #(
  parameter int DEPTH = fgcn_pkg::MAX_NODES_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fgcn_pkg::q_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]    push_data,
  output logic [IDX_W-1:0]    pop_data,
  output logic                empty
);

  logic [IDX_W-1:0] qmem [DEPTH];
  logic [CNT_W-1:0] head_r;
  logic [CNT_W-1:0] tail_r;
  logic [IDX_W-1:0] pop_data_r;

  assign empty    = (head_r == tail_r);
  assign pop_data = pop_data_r;

  // Each node enters the queue at most once, so the tail never passes the depth.
  always_ff @(posedge clk) begin
    if (ctrl.push && (int'(tail_r) < DEPTH)) begin
      qmem[tail_r[IDX_W-1:0]] <= push_data;
    end
    if (ctrl.pop) begin
      pop_data_r <= qmem[head_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (ctrl.push && (int'(tail_r) < DEPTH)) begin
        tail_r <= tail_r + CNT_W'(1);
      end
      if (ctrl.pop && !empty) begin
        head_r <= head_r + CNT_W'(1);
      end
    end
  end

endmodule

/* sv/functional_graph_cycle_nodes.sv */
// Each edge beat is accepted, then updates the target's in-degree, then the source's pointer.
// After the last edge of a set of n nodes come a degree scan, the peeling of each node
// taken from the queue until the queue is found empty, then an output scan over the n
// nodes that sends one beat per surviving node, each beat waiting on out_ready.
// Reset (rst_n, synchronous, active low) and the end of every set start a clearing pass over
// all MAX_NODES words of the node memory, during which no edge is accepted.
module functional_graph_cycle_nodes #(
  parameter int MAX_NODES = fgcn_pkg::MAX_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fgcn_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fgcn_pkg::out_beat_t out_data
);

  localparam int NODE_W = fgcn_pkg::NODE_W;
  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  // One word per node holds everything the peeling needs: whether it has been peeled,
  // its remaining in-degree and the node it points to (zero when it sent no edge).
  typedef struct packed {
    logic              removed;
    logic [CNT_W-1:0]  deg;
    logic [NODE_W-1:0] ptr;
  } word_t;

  fgcn_pkg::state_t state_r, state_nxt;

  // Node memory, one read and one write port, read data registered.
  word_t            dmem [MAX_NODES];
  word_t            rd_word_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [IDX_W-1:0] mem_ra;
  word_t            mem_wd;

  // Edge being loaded.
  logic [NODE_W-1:0] src_r;
  logic [NODE_W-1:0] tgt_r;
  logic              last_r;
  logic              cnt_ok_r;
  word_t             fwd_r;

  logic [CNT_W-1:0] edge_cnt_r;
  logic             dropped_r;
  logic [IDX_W-1:0] clr_i_r;
  logic [CNT_W-1:0] scan_i_r;
  logic             chk_v_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic [IDX_W-1:0] node_r;
  logic [IDX_W-1:0] tidx_r;
  logic [CNT_W-1:0] rm_cnt_r;
  logic [CNT_W-1:0] emit_i_r;
  logic [CNT_W-1:0] emit_cnt_r;
  logic             out_valid_r;
  fgcn_pkg::out_beat_t out_data_r;

  // Work queue.
  fgcn_pkg::q_ctrl_t q_ctrl;
  logic [IDX_W-1:0]  q_push_data;
  logic [IDX_W-1:0]  q_data;
  logic              q_empty;

  // Decoded views of the registered state.
  logic             src_ok, tgt_ok, t_ok, dec_ok;
  logic [IDX_W-1:0] src_idx, tgt_idx, in_tgt_idx, t_idx;
  word_t            inc_word, ptr_word, rm_word, dec_word;
  logic [CNT_W-1:0] cyc_total;

  fgcn_queue #(
    .DEPTH (MAX_NODES)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (q_ctrl),
    .push_data (q_push_data),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // A source or target counts only when the edge itself was kept and the node number lies
  // within capacity; an out-of-range source still adds to n.
  assign src_ok     = cnt_ok_r && (src_r != '0) && (int'(src_r) <= MAX_NODES);
  assign tgt_ok     = cnt_ok_r && (tgt_r != '0) && (int'(tgt_r) <= MAX_NODES);
  assign src_idx    = IDX_W'(src_r - NODE_W'(1));
  assign tgt_idx    = IDX_W'(tgt_r - NODE_W'(1));
  assign in_tgt_idx = IDX_W'(in_data.target_node - NODE_W'(1));

  // During peeling the word just read belongs to the popped node; its pointer matters only
  // when it lies within 1..n. A node pointing at itself is already marked removed, so it
  // is skipped here rather than read back while being written.
  assign t_idx = IDX_W'(rd_word_r.ptr - NODE_W'(1));
  assign t_ok  = (rd_word_r.ptr != '0) && (int'(rd_word_r.ptr) <= int'(edge_cnt_r)) &&
                 (t_idx != node_r);
  assign dec_ok = !rd_word_r.removed && (rd_word_r.deg != '0);

  assign cyc_total = edge_cnt_r - rm_cnt_r;

  always_comb begin
    inc_word     = rd_word_r;
    inc_word.deg = rd_word_r.deg + CNT_W'(1);
    // When the source equals the target, the word read for the source is stale by one
    // write, so the freshly incremented word is forwarded instead.
    ptr_word     = (tgt_ok && (src_idx == tgt_idx)) ? fwd_r : rd_word_r;
    ptr_word.ptr = tgt_r;
    rm_word         = rd_word_r;
    rm_word.removed = 1'b1;
    dec_word     = rd_word_r;
    dec_word.deg = rd_word_r.deg - CNT_W'(1);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fgcn_pkg::ST_CLEAR: begin
        if (clr_i_r == IDX_W'(MAX_NODES - 1)) begin
          state_nxt = fgcn_pkg::ST_LOAD;
        end
      end
      fgcn_pkg::ST_LOAD: begin
        if (in_valid) begin
          state_nxt = fgcn_pkg::ST_INC;
        end
      end
      fgcn_pkg::ST_INC: begin
        state_nxt = fgcn_pkg::ST_PTR;
      end
      fgcn_pkg::ST_PTR: begin
        state_nxt = last_r ? fgcn_pkg::ST_SCAN : fgcn_pkg::ST_LOAD;
      end
      fgcn_pkg::ST_SCAN: begin
        if ((scan_i_r == edge_cnt_r) && !chk_v_r) begin
          state_nxt = fgcn_pkg::ST_POP;
        end
      end
      fgcn_pkg::ST_POP: begin
        state_nxt = q_empty ? fgcn_pkg::ST_E_RD : fgcn_pkg::ST_NODE;
      end
      fgcn_pkg::ST_NODE: begin
        state_nxt = fgcn_pkg::ST_TGT;
      end
      fgcn_pkg::ST_TGT: begin
        state_nxt = t_ok ? fgcn_pkg::ST_DEC : fgcn_pkg::ST_POP;
      end
      fgcn_pkg::ST_DEC: begin
        state_nxt = fgcn_pkg::ST_POP;
      end
      fgcn_pkg::ST_E_RD: begin
        state_nxt = (emit_i_r == edge_cnt_r) ? fgcn_pkg::ST_CLEAR : fgcn_pkg::ST_E_CHK;
      end
      fgcn_pkg::ST_E_CHK: begin
        state_nxt = rd_word_r.removed ? fgcn_pkg::ST_E_RD : fgcn_pkg::ST_E_WAIT;
      end
      fgcn_pkg::ST_E_WAIT: begin
        if (out_ready) begin
          state_nxt = fgcn_pkg::ST_E_RD;
        end
      end
      default: begin
        state_nxt = fgcn_pkg::ST_CLEAR;
      end
    endcase
  end

  // Memory and queue control for each state.
  always_comb begin
    in_ready    = 1'b0;
    mem_ra      = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    q_ctrl      = '0;
    q_push_data = tidx_r;
    case (state_r)
      fgcn_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_i_r;
        q_ctrl.clear = 1'b1;
      end
      fgcn_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        mem_ra   = in_tgt_idx;
      end
      fgcn_pkg::ST_INC: begin
        mem_we = tgt_ok;
        mem_wa = tgt_idx;
        mem_wd = inc_word;
        mem_ra = src_idx;
      end
      fgcn_pkg::ST_PTR: begin
        mem_we = src_ok;
        mem_wa = src_idx;
        mem_wd = ptr_word;
      end
      fgcn_pkg::ST_SCAN: begin
        mem_ra      = scan_i_r[IDX_W-1:0];
        q_ctrl.push = chk_v_r && (rd_word_r.deg == '0);
        q_push_data = chk_idx_r;
      end
      fgcn_pkg::ST_POP: begin
        q_ctrl.pop = !q_empty;
      end
      fgcn_pkg::ST_NODE: begin
        mem_ra = q_data;
      end
      fgcn_pkg::ST_TGT: begin
        mem_we = 1'b1;
        mem_wa = node_r;
        mem_wd = rm_word;
        mem_ra = t_idx;
      end
      fgcn_pkg::ST_DEC: begin
        mem_we      = dec_ok;
        mem_wa      = tidx_r;
        mem_wd      = dec_word;
        q_ctrl.push = dec_ok && (rd_word_r.deg == CNT_W'(1));
      end
      fgcn_pkg::ST_E_RD: begin
        mem_ra = emit_i_r[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_wa] <= mem_wd;
    end
    rd_word_r <= dmem[mem_ra];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == fgcn_pkg::ST_LOAD && in_valid) begin
      src_r  <= in_data.source_node;
      tgt_r  <= in_data.target_node;
      last_r <= in_data.last_edge;
    end
    if (state_r == fgcn_pkg::ST_INC) begin
      fwd_r <= inc_word;
    end
    if (state_r == fgcn_pkg::ST_SCAN) begin
      chk_idx_r <= scan_i_r[IDX_W-1:0];
    end
    if (state_r == fgcn_pkg::ST_NODE) begin
      node_r <= q_data;
    end
    if (state_r == fgcn_pkg::ST_TGT) begin
      tidx_r <= t_idx;
    end
    if (state_r == fgcn_pkg::ST_E_CHK) begin
      out_data_r.cycle_node <= NODE_W'(emit_i_r + CNT_W'(1));
      out_data_r.last_node  <= (emit_cnt_r + CNT_W'(1) == cyc_total);
      out_data_r.overflow   <= dropped_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fgcn_pkg::ST_CLEAR;
      clr_i_r     <= '0;
      edge_cnt_r  <= '0;
      dropped_r   <= 1'b0;
      cnt_ok_r    <= 1'b0;
      scan_i_r    <= '0;
      chk_v_r     <= 1'b0;
      rm_cnt_r    <= '0;
      emit_i_r    <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        fgcn_pkg::ST_CLEAR: begin
          clr_i_r    <= (clr_i_r == IDX_W'(MAX_NODES - 1)) ? '0 : clr_i_r + IDX_W'(1);
          edge_cnt_r <= '0;
          dropped_r  <= 1'b0;
          scan_i_r   <= '0;
          chk_v_r    <= 1'b0;
          rm_cnt_r   <= '0;
          emit_i_r   <= '0;
          emit_cnt_r <= '0;
        end
        fgcn_pkg::ST_LOAD: begin
          if (in_valid) begin
            // Once capacity is reached further edges are dropped, but a dropped last
            // edge still closes the set.
            if (int'(edge_cnt_r) < MAX_NODES) begin
              edge_cnt_r <= edge_cnt_r + CNT_W'(1);
              cnt_ok_r   <= 1'b1;
            end else begin
              dropped_r <= 1'b1;
              cnt_ok_r  <= 1'b0;
            end
          end
        end
        fgcn_pkg::ST_SCAN: begin
          if (scan_i_r != edge_cnt_r) begin
            scan_i_r <= scan_i_r + CNT_W'(1);
            chk_v_r  <= 1'b1;
          end else begin
            chk_v_r <= 1'b0;
          end
        end
        fgcn_pkg::ST_TGT: begin
          rm_cnt_r <= rm_cnt_r + CNT_W'(1);
        end
        fgcn_pkg::ST_E_CHK: begin
          if (rd_word_r.removed) begin
            emit_i_r <= emit_i_r + CNT_W'(1);
          end else begin
            out_valid_r <= 1'b1;
          end
        end
        fgcn_pkg::ST_E_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            emit_i_r    <= emit_i_r + CNT_W'(1);
            emit_cnt_r  <= emit_cnt_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A node leaves the queue only with no remaining in-degree and only once.
  a_peel_degree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fgcn_pkg::ST_TGT |-> !rd_word_r.removed && (rd_word_r.deg == '0))
    else $error("peeled node still had in-degree or was already removed");

  // When the output scan has run past n, every surviving node has been sent.
  a_emit_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fgcn_pkg::ST_E_RD) && (emit_i_r == edge_cnt_r) |->
      emit_cnt_r == cyc_total)
    else $error("cycle node count does not match beats sent");

  a_removed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rm_cnt_r <= edge_cnt_r)
    else $error("more nodes removed than the set holds");

  // The final beat of a set is followed by the end of the output scan, never another beat.
  a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_node |=> !out_valid && !in_ready)
    else $error("beat after the final cycle node of a set");

endmodule
